@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-check wrappers; all sample on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that holds at every clock edge out of reset.
`define CFLR_CHECK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define CFLR_CHECK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CFLR_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/cflr_pkg.sv @@
// ----------------------------------------------------------------------------
// cflr_pkg
// Types, register map and byte helpers for the caseless replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package cflr_pkg;

  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned LEN_W  = 5;

  // Register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_LEN    = 3'd0;
  localparam logic [2:0] REG_OLD_LO = 3'd1;
  localparam logic [2:0] REG_OLD_HI = 3'd2;
  localparam logic [2:0] REG_NEW_LO = 3'd3;
  localparam logic [2:0] REG_NEW_HI = 3'd4;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] old_lo;
    logic [DATA_W-1:0] old_hi;
    logic [DATA_W-1:0] new_lo;
    logic [DATA_W-1:0] new_hi;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0] len_eff;  // length in force (1 when out of range)
    logic             hit;      // window front matches and replacing is enabled
  } match_t;

  // Fold ASCII upper case to lower case; every other byte is kept.
  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // Byte idx of a 16-byte pattern split over two 64-bit words.
  function automatic logic [7:0] pat_byte(input logic [DATA_W-1:0] lo,
                                          input logic [DATA_W-1:0] hi,
                                          input logic [3:0]        idx);
    logic [DATA_W-1:0] w;
    w = idx[3] ? hi : lo;
    return w[{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

@@ sv/cflr_regs.sv @@
// ----------------------------------------------------------------------------
// cflr_regs
// APB register file: pattern length and the search and replacement patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module cflr_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cflr_pkg::ADDR_W-1:0]  paddr,
  input  logic [cflr_pkg::DATA_W-1:0]  pwdata,
  output logic [cflr_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output cflr_pkg::cfg_t               cfg,
  output logic                         wr
);
  import cflr_pkg::*;

  logic [LEN_W-1:0]  len_r,    len_nxt;
  logic [DATA_W-1:0] old_lo_r, old_lo_nxt;
  logic [DATA_W-1:0] old_hi_r, old_hi_nxt;
  logic [DATA_W-1:0] new_lo_r, new_lo_nxt;
  logic [DATA_W-1:0] new_hi_r, new_hi_nxt;
  logic [2:0]        idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:3];

  always_comb begin
    len_nxt    = len_r;
    old_lo_nxt = old_lo_r;
    old_hi_nxt = old_hi_r;
    new_lo_nxt = new_lo_r;
    new_hi_nxt = new_hi_r;
    if (wr) begin
      unique case (idx)
        REG_LEN:    len_nxt    = pwdata[LEN_W-1:0];
        REG_OLD_LO: old_lo_nxt = pwdata;
        REG_OLD_HI: old_hi_nxt = pwdata;
        REG_NEW_LO: new_lo_nxt = pwdata;
        REG_NEW_HI: new_hi_nxt = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LEN:    prdata = DATA_W'(len_r);
      REG_OLD_LO: prdata = old_lo_r;
      REG_OLD_HI: prdata = old_hi_r;
      REG_NEW_LO: prdata = new_lo_r;
      REG_NEW_HI: prdata = new_hi_r;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= LEN_W'(1);
      old_lo_r <= '0;
      old_hi_r <= '0;
      new_lo_r <= '0;
      new_hi_r <= '0;
    end else begin
      len_r    <= len_nxt;
      old_lo_r <= old_lo_nxt;
      old_hi_r <= old_hi_nxt;
      new_lo_r <= new_lo_nxt;
      new_hi_r <= new_hi_nxt;
    end
  end

  assign cfg.len    = len_r;
  assign cfg.old_lo = old_lo_r;
  assign cfg.old_hi = old_hi_r;
  assign cfg.new_lo = new_lo_r;
  assign cfg.new_hi = new_hi_r;

endmodule

`default_nettype wire

@@ sv/cflr_match.sv @@
// ----------------------------------------------------------------------------
// cflr_match
// Parallel caseless compare of the window front against the search pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module cflr_match #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  cflr_pkg::cfg_t   cfg,
  input  logic [7:0]       win [MAX_PATTERN],
  output cflr_pkg::match_t res
);
  import cflr_pkg::*;

  always_comb begin
    logic       len_ok;
    logic       peq;
    logic       same;
    logic [7:0] ob;
    logic [7:0] nb;
    len_ok = (cfg.len != '0) && (int'(cfg.len) <= int'(MAX_PATTERN));
    peq    = 1'b1;
    same   = 1'b1;
    ob     = '0;
    nb     = '0;
    for (int i = 0; i < int'(MAX_PATTERN); i++) begin
      if (i < int'(cfg.len)) begin
        ob = pat_byte(cfg.old_lo, cfg.old_hi, 4'(i));
        nb = pat_byte(cfg.new_lo, cfg.new_hi, 4'(i));
        if (fold(ob) != fold(nb)) peq = 1'b0;
        if (fold(win[i]) != fold(ob)) same = 1'b0;
      end
    end
    res.len_eff = len_ok ? cfg.len : LEN_W'(1);
    // patterns equal ignoring case: never replace
    res.hit     = len_ok && !peq && same;
  end

endmodule

`default_nettype wire

@@ sv/cflr_outreg.sv @@
// ----------------------------------------------------------------------------
// cflr_outreg
// Output register for the result stream; loads on load; free if empty or read.
// ----------------------------------------------------------------------------
`default_nettype none

module cflr_outreg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic [7:0] data_i,
  input  logic       last_i,
  input  logic       ready_i,
  output logic       valid_o,
  output logic [7:0] data_o,
  output logic       last_o,
  output logic       free
);
  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;

  assign free = !valid_r || ready_i;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (ready_i) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_i;
      last_r <= last_i;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;
  assign last_o  = last_r;

endmodule

`default_nettype wire

@@ sv/caseless_fixed_length_replace.sv @@
// ----------------------------------------------------------------------------
// caseless_fixed_length_replace
// Rewrites leftmost, non-overlapping, ASCII-caseless occurrences of a search
// pattern in a byte stream with a replacement pattern of the same length.
// ----------------------------------------------------------------------------
//
//  channel | ports      | width | contents
//  --------+------------+-------+-------------------------------------------
//  in      | in_t*      | 8+1   | tdata = data_byte, tlast = last_byte
//  out     | out_t*     | 8+1   | tdata = out_byte,  tlast = out_last
//  cfg     | cfg_p*     | 64    | APB, register i at byte address 8*i
//
//  One byte in and one byte out per cycle sustained while the output is not
//  stalled; the window decides one byte (or one whole match) per cycle in a
//  single compare-and-shift pass. An output byte is presented by the output
//  register in the cycle after its decision.
//  Reset (synchronous, rst_n low) empties the window and the output register
//  and restores length 1 with all-zero patterns.
//  A stalled output freezes the window; input is taken until it holds
//  MAX_PATTERN + 1 bytes.
//
`default_nettype none
`include "assert_macros.svh"

module caseless_fixed_length_replace #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] data_byte
  input  logic                         in_tlast,
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // [7:0] out_byte
  output logic                         out_tlast,
  // configuration
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [cflr_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [cflr_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [cflr_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import cflr_pkg::*;

  // Window: the pattern length at most, plus one slot so that a full-length
  // compare and an incoming transfer can overlap.
  localparam int unsigned DEPTH = MAX_PATTERN + 1;
  localparam int unsigned FW    = $clog2(DEPTH + 1);
  localparam int unsigned CMW   = $clog2(MAX_PATTERN + 1);

  cfg_t   cfg;
  logic   cfg_wr;
  match_t mres;

  logic [7:0]       win_r [DEPTH];
  logic [7:0]       win_nxt [DEPTH];
  logic [DEPTH-1:0] wlast_r, wlast_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;      // bytes held in the window
  logic [CMW-1:0]   commit_r, commit_nxt;  // front bytes already decided
  logic             armed_r, armed_nxt;    // a transfer came in since last cfg write

  logic [7:0] cmp_win [MAX_PATTERN];
  logic       in_acc;
  logic       out_free;
  logic       busy;
  logic       lastin;
  logic       can_cmp;
  logic       take_match;
  logic       take_plain;
  logic       emit;
  logic [7:0] emit_byte;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cflr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg),
    .wr      (cfg_wr)
  );

  // --------------------------------------------------------------------------
  // Front-of-window compare
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < int'(MAX_PATTERN); i++) cmp_win[i] = win_r[i];
  end

  cflr_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .cfg (cfg),
    .win (cmp_win),
    .res (mres)
  );

  // --------------------------------------------------------------------------
  // Decision for this cycle
  // --------------------------------------------------------------------------
  assign in_tready = (fill_r != FW'(DEPTH));
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    // A buffer end inside the first len-1 held bytes means no full match can
    // start at the front any more: flush the front byte as it is.
    lastin = 1'b0;
    for (int i = 0; i < int'(DEPTH); i++) begin
      if (wlast_r[i] && (i < int'(fill_r)) && (i + 1 < int'(mres.len_eff))) lastin = 1'b1;
    end
    busy       = (commit_r != '0);
    // Hold uncommitted bytes until a transfer arrives after a cfg write, so
    // the held bytes see the complete new configuration.
    can_cmp    = armed_r && !busy && !lastin && (int'(fill_r) >= int'(mres.len_eff));
    take_match = can_cmp && mres.hit;
    take_plain = busy || (armed_r && lastin) || (can_cmp && !mres.hit);
    emit       = out_free && (take_match || take_plain);
    emit_byte  = take_match ? pat_byte(cfg.new_lo, cfg.new_hi, 4'd0) : win_r[0];
  end

  // --------------------------------------------------------------------------
  // Window update: shift out the emitted byte, drop the replacement into the
  // rest of a match, append the incoming transfer behind the held bytes.
  // --------------------------------------------------------------------------
  always_comb begin
    int pos;
    for (int i = 0; i < int'(DEPTH); i++) begin
      win_nxt[i]   = win_r[i];
      wlast_nxt[i] = wlast_r[i];
    end
    if (emit) begin
      for (int i = 0; i < int'(DEPTH) - 1; i++) begin
        win_nxt[i]   = win_r[i+1];
        wlast_nxt[i] = wlast_r[i+1];
      end
    end
    // replaced bytes keep the buffer-end flag of the bytes they stand for
    if (emit && take_match) begin
      for (int i = 0; i < int'(MAX_PATTERN) - 1; i++) begin
        if (i + 1 < int'(mres.len_eff)) win_nxt[i] = pat_byte(cfg.new_lo, cfg.new_hi, 4'(i + 1));
      end
    end
    pos = int'(fill_r) - (emit ? 1 : 0);
    if (in_acc) begin
      for (int i = 0; i < int'(DEPTH); i++) begin
        if (i == pos) begin
          win_nxt[i]   = in_tdata;
          wlast_nxt[i] = in_tlast;
        end
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r + FW'(in_acc) - FW'(emit);

    commit_nxt = commit_r;
    if (emit && take_match) commit_nxt = CMW'(mres.len_eff - LEN_W'(1));
    else if (emit && busy) commit_nxt = commit_r - CMW'(1);

    armed_nxt = armed_r;
    if (cfg_wr) armed_nxt = 1'b0;
    else if (in_acc) armed_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      commit_r <= '0;
      armed_r  <= 1'b0;
      wlast_r  <= '0;
    end else begin
      fill_r   <= fill_nxt;
      commit_r <= commit_nxt;
      armed_r  <= armed_nxt;
      wlast_r  <= wlast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < int'(DEPTH); i++) win_r[i] <= win_nxt[i];
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  cflr_outreg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (emit),
    .data_i  (emit_byte),
    .last_i  (wlast_r[0]),
    .ready_i (out_tready),
    .valid_o (out_tvalid),
    .data_o  (out_tdata),
    .last_o  (out_tlast),
    .free    (out_free)
  );

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `CFLR_CHECK(a_commit_held, int'(fill_r) >= int'(commit_r), "committed bytes exceed window fill")
  `CFLR_CHECK_IMPL(a_empty_quiet, fill_r == '0, !emit, "emit from an empty window")
  `CFLR_CHECK_NEXT(a_match_out, emit && take_match, out_tvalid, "match decision did not reach output")

endmodule

`default_nettype wire

@@ tb/sv/caseless_fixed_length_replace_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// caseless_fixed_length_replace_test
// Self-checking bench for the caseless search-and-replace stream block.
// A software model of the sliding window predicts every output byte; a
// clocked driver and monitor push random traffic with random back-pressure
// through several pattern setups and compare each transfer as it leaves.
// ----------------------------------------------------------------------------
module caseless_fixed_length_replace_test;
  import cflr_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000; // cycles with no transfer at all
  localparam int unsigned SETTLE      = 24;   // drain time after the last result
  localparam int unsigned HOLD_OFF    = 300;  // long receiver stall, in cycles

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  wire                 in_tready;
  logic [7:0]          in_tdata    = 8'h00;   // [7:0] data_byte
  logic                in_tlast    = 1'b0;
  wire                 out_tvalid;
  logic                out_tready  = 1'b0;
  wire  [7:0]          out_tdata;             // [7:0] out_byte
  wire                 out_tlast;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0]   cfg_paddr   = '0;
  logic [DATA_W-1:0]   cfg_pwdata  = '0;
  wire  [DATA_W-1:0]   cfg_prdata;
  wire                 cfg_pready;

  caseless_fixed_length_replace u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the register file, updated when a write completes.
  logic [4:0]  len_r  = 5'd1;
  logic [63:0] old_lo = '0;
  logic [63:0] old_hi = '0;
  logic [63:0] new_lo = '0;
  logic [63:0] new_hi = '0;

  // Bytes held back in the window, oldest first.
  logic [7:0]  held [0:14];
  int unsigned held_cnt = 0;

  byte_item_t  src_q[$];        // bytes waiting for the driver
  byte_item_t  out_expect[$];   // predicted output transfers, oldest first

  int unsigned queued_cnt   = 0;
  int unsigned taken_cnt    = 0;
  int unsigned results_seen = 0;
  int unsigned fail_cnt     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned holds_done   = 0;
  bit          steady       = 1'b0;  // set for phases with no idling at all

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return c | 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] key_at(input logic [63:0] lo, input logic [63:0] hi,
                                        input int unsigned idx);
    logic [63:0] w;
    w = (idx < 8) ? lo : hi;
    return w[(idx % 8) * 8 +: 8];
  endfunction

  // Advance the window by one input byte and queue every byte it releases.
  function automatic void replace_step(input logic [7:0] b, input logic lst);
    logic [7:0]  span [0:15];
    logic [7:0]  emit [0:15];
    int unsigned n_len, cnt, pos, k, n;
    bit          on, hit;
    n_len = 32'(len_r);
    n     = 0;
    if (n_len < 1 || n_len > 16) begin
      // out-of-range length: plain pass-through
      n_len = 1;
      on    = 1'b0;
    end else begin
      // patterns equal ignoring case never replace
      on = 1'b0;
      for (k = 0; k < n_len; k++)
        if (lower_ascii(key_at(old_lo, old_hi, k)) != lower_ascii(key_at(new_lo, new_hi, k)))
          on = 1'b1;
    end
    for (k = 0; k < held_cnt; k++) span[k] = held[k];
    span[held_cnt] = b;
    cnt = held_cnt + 1;
    pos = 0;
    // a shortened length drains the excess here, at once
    while (cnt - pos >= n_len) begin
      hit = on;
      for (k = 0; k < n_len; k++)
        if (lower_ascii(span[pos + k]) != lower_ascii(key_at(old_lo, old_hi, k)))
          hit = 1'b0;
      if (hit) begin
        for (k = 0; k < n_len; k++) begin
          emit[n] = key_at(new_lo, new_hi, k);
          n++;
        end
        pos += n_len;
      end else begin
        emit[n] = span[pos];
        n++;
        pos++;
      end
    end
    if (lst) begin
      // flush whatever is still held
      while (pos < cnt) begin
        emit[n] = span[pos];
        n++;
        pos++;
      end
      held_cnt = 0;
    end else begin
      held_cnt = cnt - pos;
      for (k = 0; k < held_cnt; k++) held[k] = span[pos + k];
    end
    for (k = 0; k < n; k++)
      out_expect.push_back('{data: emit[k], last: lst && (k == n - 1)});
  endfunction

  // Mostly back-to-back, sometimes short gaps, rarely long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: predict on each accepted transfer, then offer the next byte
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_item_t nxt;
    logic       v;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        replace_step(in_tdata, in_tlast);
        taken_cnt <= taken_cnt + 1;
      end
      // hold the current byte while it is not taken
      if (!in_tvalid || in_tready) begin
        v = 1'b0;
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
        end else if (src_q.size() > 0) begin
          nxt       = src_q.pop_front();
          in_tdata <= nxt.data;
          in_tlast <= nxt.last;
          v         = 1'b1;
          send_gap  = pick_gap();
        end
        in_tvalid <= v;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: check each transfer, then decide the next ready
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_item_t want;
    logic       r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen = results_seen + 1;
        if (out_expect.size() == 0) begin
          $display("%0t: unexpected output byte %02h last %0b", $time, out_tdata, out_tlast);
          fail_cnt = fail_cnt + 1;
        end else begin
          want = out_expect.pop_front();
          if (out_tdata !== want.data) begin
            $display("%0t: out_tdata expected %02h actual %02h", $time, want.data, out_tdata);
            fail_cnt = fail_cnt + 1;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: out_tlast expected %0b actual %0b", $time, want.last, out_tlast);
            fail_cnt = fail_cnt + 1;
          end
        end
        stall_left = pick_gap();
      end
      // One long hold-off while the sender still has plenty queued, so the
      // window fills up and the input side has to stall.
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        r = 1'b0;
      end else if (holds_done == 0 && results_seen >= 40 && src_q.size() >= 30) begin
        hold_left  = HOLD_OFF - 1;
        holds_done = holds_done + 1;
        r = 1'b0;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        r = 1'b0;
      end else begin
        r = 1'b1;
      end
      out_tready <= r;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any transfer on any port counts as progress
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_item(input logic [7:0] d, input logic l);
    src_q.push_back('{data: d, last: l});
    queued_cnt++;
  endtask

  // Setup cycle, then access cycle; the register lands on the access edge.
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_LEN:    len_r  = val[4:0];
      REG_OLD_LO: old_lo = val;
      REG_OLD_HI: old_hi = val;
      REG_NEW_LO: new_lo = val;
      REG_NEW_HI: new_hi = val;
      default: ;
    endcase
  endtask

  task automatic load_cfg(input logic [4:0] l, input logic [63:0] ol, input logic [63:0] oh,
                          input logic [63:0] nl, input logic [63:0] nh);
    cfg_write(REG_LEN, {59'd0, l});
    cfg_write(REG_OLD_LO, ol);
    cfg_write(REG_OLD_HI, oh);
    cfg_write(REG_NEW_LO, nl);
    cfg_write(REG_NEW_HI, nh);
  endtask

  // Wait for every byte to be taken and every prediction to come back, then
  // let the window settle before touching the registers.
  task automatic drain();
    while (taken_cnt != queued_cnt || out_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(0, 1))
      return c ^ 8'h20;
    return c;
  endfunction

  // Small alphabet so partial and overlapping matches are common.
  function automatic logic [7:0] pick_key_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return flip_case(8'(8'h61 + $urandom_range(0, 2)));
    if (r < 70) return 8'h00;
    if (r < 78) return $urandom_range(0, 1) ? 8'hC1 : 8'hE1;
    return 8'($urandom_range(0, 255));
  endfunction

  // One pattern setup followed by a stream built mostly from pattern copies.
  task automatic random_phase(input int unsigned n_items, input bit extreme, input bit close);
    logic [7:0]   key [0:15];
    logic [7:0]   seg [0:15];
    logic [127:0] old_w, new_w;
    logic [4:0]   len_code;
    int unsigned  plen, seg_n, k, r, made;
    bit           eq_case, frame_end;
    r = $urandom_range(0, 99);
    if (extreme)      len_code = 5'd16;
    else if (r < 70)  len_code = 5'($urandom_range(1, 6));
    else if (r < 88)  len_code = 5'($urandom_range(7, 16));
    else if (r < 94)  len_code = 5'd0;
    else              len_code = 5'($urandom_range(17, 31));
    plen    = (len_code >= 1 && len_code <= 16) ? 32'(len_code) : 1;
    eq_case = ($urandom_range(0, 99) < 15);
    for (k = 0; k < 16; k++) begin
      key[k] = extreme ? 8'hFF : pick_key_byte();
      old_w[k * 8 +: 8] = key[k];
      if (extreme)      new_w[k * 8 +: 8] = 8'h00;
      else if (eq_case) new_w[k * 8 +: 8] = flip_case(key[k]);
      else              new_w[k * 8 +: 8] = 8'($urandom_range(0, 255));
    end
    load_cfg(len_code, old_w[63:0], old_w[127:64], new_w[63:0], new_w[127:64]);
    made = 0;
    while (made < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        seg_n = plen;
        for (k = 0; k < seg_n; k++) seg[k] = flip_case(key[k]);
      end else if (r < 60) begin
        seg_n = $urandom_range(1, plen);
        for (k = 0; k < seg_n; k++) seg[k] = flip_case(key[k]);
      end else if (r < 78) begin
        seg_n  = 1;
        seg[0] = flip_case(key[$urandom_range(0, plen - 1)]);
      end else if (r < 88) begin
        // near miss: toggles the case bit even on bytes that do not fold
        seg_n  = 1;
        seg[0] = key[$urandom_range(0, plen - 1)] ^ 8'h20;
      end else begin
        seg_n  = 1;
        seg[0] = 8'($urandom_range(0, 255));
      end
      if (made + seg_n >= n_items)
        frame_end = close || ($urandom_range(0, 99) < 80);
      else
        frame_end = ($urandom_range(0, 99) < 6);
      for (k = 0; k < seg_n; k++) push_item(seg[k], frame_end && (k == seg_n - 1));
      made += seg_n;
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned ph;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setup: length 1, all-zero patterns are equal, bytes pass.
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b1);
    drain();

    // "abc" -> 00 FF 'Z'; mixed case hits, leftmost after a false start.
    load_cfg(5'd3, 64'h636261, 64'd0, 64'h5AFF00, 64'd0);
    push_item(8'h41, 1'b0);
    push_item(8'h62, 1'b0);
    push_item(8'h43, 1'b0);
    push_item(8'h61, 1'b0);
    push_item(8'h61, 1'b0);
    push_item(8'h42, 1'b0);
    push_item(8'h63, 1'b1);
    drain();

    // Non-letters must compare exactly: C1 vs E1 and '[' vs '{'.
    load_cfg(5'd2, 64'h5BC1, 64'd0, 64'h3231, 64'd0);
    push_item(8'hE1, 1'b0);
    push_item(8'h7B, 1'b0);
    push_item(8'hC1, 1'b0);
    push_item(8'h5B, 1'b0);
    push_item(8'hC1, 1'b0);
    push_item(8'h7B, 1'b1);
    drain();

    // Patterns equal ignoring case: no replacement at all.
    load_cfg(5'd2, 64'h6261, 64'd0, 64'h4241, 64'd0);
    push_item(8'h61, 1'b0);
    push_item(8'h62, 1'b1);
    drain();

    // Out-of-range lengths act as plain pass-through.
    load_cfg(5'd0, 64'h61, 64'd0, 64'h7A, 64'd0);
    push_item(8'h61, 1'b0);
    drain();
    cfg_write(REG_LEN, 64'd31);
    push_item(8'h41, 1'b1);
    drain();

    // Shorten the length while bytes are held; they drain on the next byte.
    load_cfg(5'd4, 64'h64636261, 64'd0, 64'h7A797877, 64'd0);
    push_item(8'h71, 1'b0);
    push_item(8'h72, 1'b0);
    push_item(8'h73, 1'b0);
    drain();
    cfg_write(REG_LEN, 64'd1);
    push_item(8'h41, 1'b1);
    drain();

    // Random part; the first phase is long enough for the receiver hold-off.
    for (ph = 0; ph < 11; ph++) begin
      steady = (ph % 4 == 2);
      random_phase((ph == 0) ? 120 : 35, ph == 5, ph == 10);
    end
    steady = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && out_expect.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

@@ caseless_fixed_length_replace.f @@
+incdir+sv
sv/cflr_pkg.sv
sv/cflr_regs.sv
sv/cflr_match.sv
sv/cflr_outreg.sv
sv/caseless_fixed_length_replace.sv
tb/sv/caseless_fixed_length_replace_test.sv
